### rtl/c6502_pkg.sv
`default_nettype none
package c6502_pkg;

	localparam logic [6:0] OP_ADC = 7'd0;
	localparam logic [6:0] OP_AND = 7'd1;
	localparam logic [6:0] OP_ASL = 7'd2;
	localparam logic [6:0] OP_BCC = 7'd3;
	localparam logic [6:0] OP_BCS = 7'd4;
	localparam logic [6:0] OP_BEQ = 7'd5;
	localparam logic [6:0] OP_BIT = 7'd6;
	localparam logic [6:0] OP_BMI = 7'd7;
	localparam logic [6:0] OP_BNE = 7'd8;
	localparam logic [6:0] OP_BPL = 7'd9;
	localparam logic [6:0] OP_BRK = 7'd10;
	localparam logic [6:0] OP_BVC = 7'd11;
	localparam logic [6:0] OP_BVS = 7'd12;
	localparam logic [6:0] OP_CLC = 7'd13;
	localparam logic [6:0] OP_CLD = 7'd14;
	localparam logic [6:0] OP_CLI = 7'd15;
	localparam logic [6:0] OP_CLV = 7'd16;
	localparam logic [6:0] OP_CMP = 7'd17;
	localparam logic [6:0] OP_CPX = 7'd18;
	localparam logic [6:0] OP_CPY = 7'd19;
	localparam logic [6:0] OP_DEC = 7'd20;
	localparam logic [6:0] OP_DEX = 7'd21;
	localparam logic [6:0] OP_DEY = 7'd22;
	localparam logic [6:0] OP_EOR = 7'd23;
	localparam logic [6:0] OP_INC = 7'd24;
	localparam logic [6:0] OP_INX = 7'd25;
	localparam logic [6:0] OP_INY = 7'd26;
	localparam logic [6:0] OP_JMP = 7'd27;
	localparam logic [6:0] OP_JSR = 7'd28;
	localparam logic [6:0] OP_LDA = 7'd29;
	localparam logic [6:0] OP_LDX = 7'd30;
	localparam logic [6:0] OP_LDY = 7'd31;
	localparam logic [6:0] OP_LSR = 7'd32;
	localparam logic [6:0] OP_ORA = 7'd34;
	localparam logic [6:0] OP_PHA = 7'd35;
	localparam logic [6:0] OP_PHP = 7'd36;
	localparam logic [6:0] OP_PLA = 7'd37;
	localparam logic [6:0] OP_PLP = 7'd38;
	localparam logic [6:0] OP_ROL = 7'd39;
	localparam logic [6:0] OP_ROR = 7'd40;
	localparam logic [6:0] OP_RTI = 7'd41;
	localparam logic [6:0] OP_RTS = 7'd42;
	localparam logic [6:0] OP_SBC = 7'd43;
	localparam logic [6:0] OP_SEC = 7'd44;
	localparam logic [6:0] OP_SED = 7'd45;
	localparam logic [6:0] OP_SEI = 7'd46;
	localparam logic [6:0] OP_STA = 7'd47;
	localparam logic [6:0] OP_STX = 7'd48;
	localparam logic [6:0] OP_STY = 7'd49;
	localparam logic [6:0] OP_TAX = 7'd50;
	localparam logic [6:0] OP_TAY = 7'd51;
	localparam logic [6:0] OP_TSX = 7'd52;
	localparam logic [6:0] OP_TXA = 7'd53;
	localparam logic [6:0] OP_TXS = 7'd54;
	localparam logic [6:0] OP_TYA = 7'd55;
	localparam logic [6:0] OP_AHX = 7'd56;
	localparam logic [6:0] OP_ALR = 7'd57;
	localparam logic [6:0] OP_ANC = 7'd58;
	localparam logic [6:0] OP_ARR = 7'd59;
	localparam logic [6:0] OP_AXS = 7'd60;
	localparam logic [6:0] OP_DCP = 7'd61;
	localparam logic [6:0] OP_ISC = 7'd62;
	localparam logic [6:0] OP_KIL = 7'd63;
	localparam logic [6:0] OP_LAS = 7'd64;
	localparam logic [6:0] OP_LAX = 7'd65;
	localparam logic [6:0] OP_RLA = 7'd66;
	localparam logic [6:0] OP_RRA = 7'd67;
	localparam logic [6:0] OP_SAX = 7'd68;
	localparam logic [6:0] OP_SHX = 7'd69;
	localparam logic [6:0] OP_SHY = 7'd70;
	localparam logic [6:0] OP_SLO = 7'd71;
	localparam logic [6:0] OP_SRE = 7'd72;
	localparam logic [6:0] OP_TAS = 7'd73;
	localparam logic [6:0] OP_XAA = 7'd74;

	localparam logic [1:0] KIND_ACC = 2'd0;
	localparam logic [1:0] KIND_MEM = 2'd2;

	localparam logic [15:0] PAGE_MASK = 16'hFF00;
	localparam logic [7:0] STATUS_RESET = 8'h24;
	localparam logic [7:0] SP_RESET = 8'hFD;

	localparam int QDEPTH = 2;
	localparam int INW = 80;

	typedef struct packed {
		logic [6:0]  func;
		logic [1:0]  kind;
		logic [7:0]  opv;
		logic [15:0] addr;
		logic [15:0] pc;
		logic [7:0]  sb0;
		logic [7:0]  sb1;
		logic [7:0]  sb2;
	} instr_t;

	typedef struct packed {
		logic [15:0] new_pc;
		logic        wv;
		logic [15:0] waddr;
		logic [7:0]  wdata;
		logic        last;
		logic [1:0]  extra;
		logic        halt;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  s;
		logic [7:0]  p;
	} result_t;

endpackage
`default_nettype wire

### rtl/c6502_front.sv
`default_nettype none
module c6502_front import c6502_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire instr_t            in_item,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output instr_t                 q_item
);
	// Two-entry queue decoupling the input stream from execution.
	instr_t    mem_q [QDEPTH];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic      push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

### rtl/c6502_back.sv
`default_nettype none
module c6502_back import c6502_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [15:0] cfg_data,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  wire instr_t      q_item,
	output logic             r_valid,
	input  wire logic        r_ready,
	output result_t          r_item
);
	logic [7:0] a_q, x_q, y_q, s_q, p_q;
	logic       halt_q;
	logic [15:0] irq_q;
	logic [1:0] beat_q;

	// Combinational execution of the head instruction.
	logic [7:0] a, x, y, s, p, v, r, hi1, t;
	logic [8:0] sum;
	logic [15:0] npc, pcm1, off, bpc;
	logic [1:0] extra, nw;
	logic [15:0] wa [3];
	logic [7:0]  wd [3];
	logic        hlt, br, br_en, do_adc, st_en;
	logic [7:0]  adc_v, st_v;
	instr_t      i;

	assign i = q_item;

	always_comb begin
		a = a_q; x = x_q; y = y_q; s = s_q; p = p_q; hlt = halt_q;
		npc = i.pc; extra = 2'd0; nw = 2'd0;
		wa[0] = 16'd0; wa[1] = 16'd0; wa[2] = 16'd0;
		wd[0] = 8'd0; wd[1] = 8'd0; wd[2] = 8'd0;
		v = (i.kind == KIND_ACC) ? a_q : i.opv;
		hi1 = i.addr[15:8] + 8'd1;
		pcm1 = i.pc - 16'd1;
		off = 16'd0; bpc = 16'd0;
		br = 1'b0; br_en = 1'b0; do_adc = 1'b0; adc_v = 8'd0;
		st_en = 1'b0; st_v = 8'd0; r = 8'd0; t = 8'd0; sum = 9'd0;
		if (!halt_q) begin
			unique case (i.func) inside
				OP_ADC: begin do_adc = 1'b1; adc_v = v; end
				OP_SBC: begin do_adc = 1'b1; adc_v = ~v; end
				OP_AND: begin a = a_q & v; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_ORA: begin a = a_q | v; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_EOR: begin a = a_q ^ v; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_ASL, OP_SLO: begin
					r = {v[6:0], 1'b0}; p[0] = v[7]; st_en = 1'b1; st_v = r;
					p[7] = r[7]; p[1] = (r == 8'd0);
					if (i.func == OP_SLO) begin
						a = a_q | r; if (i.kind == KIND_ACC) a = r | r;
						p[7] = a[7]; p[1] = (a == 8'd0);
					end
				end
				OP_ROL, OP_RLA: begin
					r = {v[6:0], p_q[0]}; p[0] = v[7]; st_en = 1'b1; st_v = r;
					p[7] = r[7]; p[1] = (r == 8'd0);
					if (i.func == OP_RLA) begin
						a = (i.kind == KIND_ACC) ? r : (a_q & r);
						p[7] = a[7]; p[1] = (a == 8'd0);
					end
				end
				OP_LSR, OP_SRE: begin
					r = {1'b0, v[7:1]}; p[0] = v[0]; st_en = 1'b1; st_v = r;
					p[7] = r[7]; p[1] = (r == 8'd0);
					if (i.func == OP_SRE) begin
						a = (i.kind == KIND_ACC) ? 8'd0 : (a_q ^ r);
						p[7] = a[7]; p[1] = (a == 8'd0);
					end
				end
				OP_ROR, OP_RRA: begin
					r = {p_q[0], v[7:1]}; p[0] = v[0]; st_en = 1'b1; st_v = r;
					p[7] = r[7]; p[1] = (r == 8'd0);
					if (i.func == OP_RRA) begin do_adc = 1'b1; adc_v = r; end
				end
				OP_BCC: begin br_en = 1'b1; br = !p_q[0]; end
				OP_BCS: begin br_en = 1'b1; br = p_q[0]; end
				OP_BNE: begin br_en = 1'b1; br = !p_q[1]; end
				OP_BEQ: begin br_en = 1'b1; br = p_q[1]; end
				OP_BPL: begin br_en = 1'b1; br = !p_q[7]; end
				OP_BMI: begin br_en = 1'b1; br = p_q[7]; end
				OP_BVC: begin br_en = 1'b1; br = !p_q[6]; end
				OP_BVS: begin br_en = 1'b1; br = p_q[6]; end
				OP_BIT: begin p[7] = v[7]; p[6] = v[6]; p[1] = ((a_q & v) == 8'd0); end
				OP_BRK: begin
					nw = 2'd3;
					wa[0] = {8'h01, s_q}; wd[0] = pcm1[15:8];
					wa[1] = {8'h01, s_q - 8'd1}; wd[1] = pcm1[7:0];
					wa[2] = {8'h01, s_q - 8'd2}; wd[2] = p_q | 8'h10;
					s = s_q - 8'd3; p[2] = 1'b1; npc = irq_q;
				end
				OP_CLC: p[0] = 1'b0;
				OP_CLD: p[3] = 1'b0;
				OP_CLI: p[2] = 1'b0;
				OP_CLV: p[6] = 1'b0;
				OP_SEC: p[0] = 1'b1;
				OP_SED: p[3] = 1'b1;
				OP_SEI: p[2] = 1'b1;
				OP_CMP: begin t = a_q - v; p[0] = a_q >= v; p[7] = t[7]; p[1] = (t == 8'd0); end
				OP_CPX: begin t = x_q - v; p[0] = x_q >= v; p[7] = t[7]; p[1] = (t == 8'd0); end
				OP_CPY: begin t = y_q - v; p[0] = y_q >= v; p[7] = t[7]; p[1] = (t == 8'd0); end
				OP_DEC, OP_DCP: begin
					r = v - 8'd1; st_en = 1'b1; st_v = r;
					p[7] = r[7]; p[1] = (r == 8'd0);
					if (i.func == OP_DCP) begin
						t = ((i.kind == KIND_ACC) ? r : a_q) - r;
						p[0] = ((i.kind == KIND_ACC) ? r : a_q) >= r;
						p[7] = t[7]; p[1] = (t == 8'd0);
					end
				end
				OP_INC, OP_ISC: begin
					r = v + 8'd1; st_en = 1'b1; st_v = r;
					p[7] = r[7]; p[1] = (r == 8'd0);
					if (i.func == OP_ISC) begin do_adc = 1'b1; adc_v = ~r; end
				end
				OP_DEX: begin x = x_q - 8'd1; p[7] = x[7]; p[1] = (x == 8'd0); end
				OP_DEY: begin y = y_q - 8'd1; p[7] = y[7]; p[1] = (y == 8'd0); end
				OP_INX: begin x = x_q + 8'd1; p[7] = x[7]; p[1] = (x == 8'd0); end
				OP_INY: begin y = y_q + 8'd1; p[7] = y[7]; p[1] = (y == 8'd0); end
				OP_JMP: npc = i.addr;
				OP_JSR: begin
					nw = 2'd2;
					wa[0] = {8'h01, s_q}; wd[0] = pcm1[15:8];
					wa[1] = {8'h01, s_q - 8'd1}; wd[1] = pcm1[7:0];
					s = s_q - 8'd2; npc = i.addr;
				end
				OP_LDA: begin a = v; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_LDX: begin x = v; p[7] = x[7]; p[1] = (x == 8'd0); end
				OP_LDY: begin y = v; p[7] = y[7]; p[1] = (y == 8'd0); end
				OP_PHA: begin nw = 2'd1; wa[0] = {8'h01, s_q}; wd[0] = a_q; s = s_q - 8'd1; end
				OP_PHP: begin
					nw = 2'd1; wa[0] = {8'h01, s_q}; wd[0] = p_q | 8'h10; s = s_q - 8'd1;
				end
				OP_PLA: begin a = i.sb0; s = s_q + 8'd1; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_PLP: begin p = {i.sb0[7:6], p_q[5:4], i.sb0[3:0]}; s = s_q + 8'd1; end
				OP_RTI: begin
					p = {i.sb0[7:6], p_q[5:4], i.sb0[3:0]}; s = s_q + 8'd3;
					npc = {i.sb2, i.sb1};
				end
				OP_RTS: begin npc = {i.sb1, i.sb0} + 16'd1; s = s_q + 8'd2; end
				OP_STA: begin st_en = 1'b1; st_v = a_q; end
				OP_STX: begin st_en = 1'b1; st_v = x_q; end
				OP_STY: begin st_en = 1'b1; st_v = y_q; end
				OP_SAX: begin st_en = 1'b1; st_v = a_q & x_q; end
				OP_TAX: begin x = a_q; p[7] = x[7]; p[1] = (x == 8'd0); end
				OP_TAY: begin y = a_q; p[7] = y[7]; p[1] = (y == 8'd0); end
				OP_TSX: begin x = s_q; p[7] = x[7]; p[1] = (x == 8'd0); end
				OP_TXA: begin a = x_q; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_TYA: begin a = y_q; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_TXS: s = x_q;
				OP_AHX: begin nw = 2'd1; wa[0] = i.addr; wd[0] = a_q & x_q & hi1; end
				OP_SHX: begin nw = 2'd1; wa[0] = i.addr; wd[0] = x_q & hi1; end
				OP_SHY: begin nw = 2'd1; wa[0] = i.addr; wd[0] = y_q & hi1; end
				OP_TAS: begin
					s = a_q & x_q; nw = 2'd1; wa[0] = i.addr; wd[0] = s & hi1;
				end
				OP_ALR: begin
					t = a_q & v; a = {1'b0, t[7:1]}; p[0] = t[0];
					p[7] = 1'b0; p[1] = (a == 8'd0);
				end
				OP_ANC: begin
					a = a_q & v; p[7] = a[7]; p[1] = (a == 8'd0); p[0] = a[7];
				end
				OP_ARR: begin
					t = a_q & v; a = {p_q[0], t[7:1]};
					p[7] = a[7]; p[1] = (a == 8'd0); p[0] = a[6]; p[6] = a[6] ^ a[5];
				end
				OP_AXS: begin
					t = a_q & x_q; x = t - v; p[0] = t >= v;
					p[7] = x[7]; p[1] = (x == 8'd0);
				end
				OP_KIL: hlt = 1'b1;
				OP_LAS: begin a = v & s_q; x = a; s = a; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_LAX: begin a = v; x = v; p[7] = a[7]; p[1] = (a == 8'd0); end
				OP_XAA: begin a = x_q & v; p[7] = a[7]; p[1] = (a == 8'd0); end
				default: ;
			endcase
			// Store target: A for the accumulator form (but not SLO, RLA, SRE), a memory beat for memory.
			if (st_en) begin
				if (i.kind == KIND_ACC && i.func != OP_SLO && i.func != OP_RLA &&
						i.func != OP_SRE) a = st_v;
				else if (i.kind == KIND_MEM) begin
					nw = 2'd1; wa[0] = i.addr; wd[0] = st_v;
				end
			end
			if (do_adc) begin
				t = (i.kind == KIND_ACC && st_en) ? st_v : a_q;
				sum = {1'b0, t} + {1'b0, adc_v} + {8'd0, p[0]};
				a = sum[7:0];
				p[6] = (~(t[7] ^ adc_v[7])) & (t[7] ^ a[7]);
				p[0] = sum[8]; p[7] = a[7]; p[1] = (a == 8'd0);
			end
			if (i.func == OP_DCP && i.kind == KIND_ACC) a = r;
			if (br_en && br) begin
				off = {{8{i.opv[7]}}, i.opv};
				bpc = i.pc + off;
				npc = bpc;
				extra = ((i.pc & PAGE_MASK) != (bpc & PAGE_MASK)) ? 2'd2 : 2'd1;
			end
		end
	end

	// Output register; the last beat of an item pops it from the queue.
	logic [1:0] nres, idx;
	logic       is_last, out_free, load;
	assign nres = (nw == 2'd0) ? 2'd1 : nw;
	assign idx = beat_q;
	assign is_last = (beat_q + 2'd1 == nres);
	assign out_free = !r_valid || r_ready;
	assign load = q_valid && out_free;
	assign q_ready = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			r_item.new_pc <= npc;
			r_item.wv <= (nw != 2'd0);
			r_item.waddr <= wa[idx];
			r_item.wdata <= wd[idx];
			r_item.last <= is_last;
			r_item.extra <= extra;
			r_item.halt <= hlt;
			r_item.a <= a;
			r_item.x <= x;
			r_item.y <= y;
			r_item.s <= s;
			r_item.p <= p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0;
			s_q <= SP_RESET; p_q <= STATUS_RESET; halt_q <= 1'b0;
			irq_q <= 16'd0; beat_q <= 2'd0; r_valid <= 1'b0;
		end else begin
			if (cfg_valid) irq_q <= cfg_data;
			if (out_free) r_valid <= q_valid;
			if (load) beat_q <= is_last ? 2'd0 : beat_q + 2'd1;
			if (q_ready) begin
				a_q <= a; x_q <= x; y_q <= y; s_q <= s; p_q <= p; halt_q <= hlt;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/cpu6502_execute_unit_core.sv
// 6502 execute unit. s_axis carries one decoded instruction per beat; m_axis
// returns one result beat per memory write the instruction makes (BRK three,
// JSR two, pushes and stores one) or a single beat when nothing is written,
// with tlast on the final beat of each instruction.
// The input lands in a two-entry queue; the execute stage evaluates the head
// instruction combinationally and registers the result, so an input beat
// passes through the queue and then the result register. Throughput is one
// instruction per cycle for all single-beat instructions while m_axis is ready;
// BRK and JSR hold the queue head for one result beat per write, one write a beat.
// cfg writes irq_vector (loaded into PC by BRK) and are taken at any time.
// Reset clears A, X, Y, sets S to FD and P to 24, clears the halt flag, the
// queue and irq_vector. A stalled m_axis holds its beat; the queue then fills
// and s_axis_tready drops. After KIL every instruction yields one beat with
// halt set and the state unchanged until reset.
`default_nettype none
module cpu6502_execute_unit_core import c6502_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           s_axis_tvalid,
	output logic                s_axis_tready,
	// func, operand_kind, operand_value, address, pc_in, stack_byte0..2,
	// seven zero bits
	input  wire logic [INW-1:0] s_axis_tdata,
	output logic                m_axis_tvalid,
	input  wire logic           m_axis_tready,
	// new_pc, write_valid, write_address, write_data, extra_cycles, halt,
	// a_value, x_value, y_value, s_value, p_value, twelve zero bits
	output logic [95:0]         m_axis_tdata,
	output logic                m_axis_tlast
);
	instr_t  in_item, q_item;
	result_t r_item;
	logic    q_valid, q_ready;

	assign cfg_ready = 1'b1;
	assign in_item.func = s_axis_tdata[6:0];
	assign in_item.kind = s_axis_tdata[8:7];
	assign in_item.opv = s_axis_tdata[16:9];
	assign in_item.addr = s_axis_tdata[32:17];
	assign in_item.pc = s_axis_tdata[48:33];
	assign in_item.sb0 = s_axis_tdata[56:49];
	assign in_item.sb1 = s_axis_tdata[64:57];
	assign in_item.sb2 = s_axis_tdata[72:65];

	c6502_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	c6502_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_item(r_item)
	);

	assign m_axis_tdata = {12'd0, r_item.p, r_item.s, r_item.y, r_item.x, r_item.a,
		r_item.halt, r_item.extra, r_item.wdata, r_item.waddr, r_item.wv,
		r_item.new_pc};
	assign m_axis_tlast = r_item.last;
endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb import c6502_pkg::*; ();

	localparam logic [6:0] OP_NOP_CODE = 7'd33;
	localparam logic [1:0] KIND_IMM = 2'd1;
	localparam logic [1:0] KIND_IMP = 2'd3;
	localparam int FL_C = 0, FL_Z = 1, FL_I = 2, FL_D = 3, FL_B = 4, FL_U = 5, FL_V = 6;
	localparam int FL_N = 7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// func, operand_kind, operand_value, address, pc_in, stack_byte0..2
	logic [79:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// new_pc, write_valid, write_address, write_data, extra_cycles, halt,
	// a_value, x_value, y_value, s_value, p_value
	logic [95:0] m_axis_tdata;
	logic        m_axis_tlast;

	cpu6502_execute_unit_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Predicted CPU state.
	logic [7:0]  reg_a, reg_x, reg_y, reg_s, reg_p;
	logic        cpu_halted;
	logic [15:0] irq_vec;
	logic [15:0] mem_wr_addr [3];
	logic [7:0]  mem_wr_data [3];
	int          mem_wr_cnt;
	logic [1:0]  cur_kind;
	logic [15:0] cur_addr;

	result_t pending_results[$];
	int errors = 0;
	int burst_left = 0;
	bit no_gaps = 0;
	bit hold_req = 0;

	function automatic void set_nz(input logic [7:0] v);
		reg_p[FL_N] = v[7];
		reg_p[FL_Z] = (v == 8'h00);
	endfunction

	function automatic void emit_write(input logic [15:0] a, input logic [7:0] d);
		if (mem_wr_cnt < 3) begin
			mem_wr_addr[mem_wr_cnt] = a;
			mem_wr_data[mem_wr_cnt] = d;
			mem_wr_cnt++;
		end
	endfunction

	function automatic void stack_push(input logic [7:0] d);
		emit_write({8'h01, reg_s}, d);
		reg_s = reg_s - 8'd1;
	endfunction

	function automatic void store_val(input logic [7:0] v);
		if (cur_kind == KIND_ACC)
			reg_a = v;
		else if (cur_kind == KIND_MEM)
			emit_write(cur_addr, v);
	endfunction

	function automatic void add_carry(input logic [7:0] v);
		logic [8:0] sum;
		logic [7:0] r;
		sum = {1'b0, reg_a} + {1'b0, v} + {8'd0, reg_p[FL_C]};
		r = sum[7:0];
		reg_p[FL_V] = (~(reg_a ^ v) & (reg_a ^ r) & 8'h80) != 0;
		reg_p[FL_C] = sum[8];
		reg_a = r;
		set_nz(reg_a);
	endfunction

	function automatic logic [7:0] compare(input logic [7:0] r, input logic [7:0] v);
		logic [7:0] d;
		d = r - v;
		reg_p[FL_C] = (r >= v);
		set_nz(d);
		return d;
	endfunction

	// 0 ASL, 1 ROL, 2 LSR, 3 ROR
	function automatic logic [7:0] shift_val(input int k, input logic [7:0] v);
		logic [7:0] r;
		case (k)
			0: r = {v[6:0], 1'b0};
			1: r = {v[6:0], reg_p[FL_C]};
			2: r = {1'b0, v[7:1]};
			default: r = {reg_p[FL_C], v[7:1]};
		endcase
		reg_p[FL_C] = (k < 2) ? v[7] : v[0];
		set_nz(r);
		return r;
	endfunction

	function automatic logic [7:0] shift_store(input int k, input logic [7:0] v);
		logic [7:0] r;
		r = shift_val(k, v);
		store_val(r);
		return r;
	endfunction

	function automatic logic [7:0] step_store(input logic [7:0] v, input bit up);
		logic [7:0] r;
		r = up ? v + 8'd1 : v - 8'd1;
		store_val(r);
		set_nz(r);
		return r;
	endfunction

	function automatic void execute_instr(input instr_t it);
		logic [7:0]  v, hi1, r;
		logic [15:0] npc, ret, off;
		logic [1:0]  extra;
		logic        taken;
		int          n;
		result_t     res;
		cur_kind = it.kind;
		cur_addr = it.addr;
		mem_wr_cnt = 0;
		npc = it.pc;
		extra = 2'd0;
		taken = 1'b0;
		ret = it.pc - 16'd1;
		v = (it.kind == KIND_ACC) ? reg_a : it.opv;
		hi1 = it.addr[15:8] + 8'd1;
		if (!cpu_halted) begin
			case (it.func)
				OP_ADC: add_carry(v);
				OP_SBC: add_carry(~v);
				OP_AND: begin reg_a &= v; set_nz(reg_a); end
				OP_ORA: begin reg_a |= v; set_nz(reg_a); end
				OP_EOR: begin reg_a ^= v; set_nz(reg_a); end
				OP_ASL: r = shift_store(0, v);
				OP_ROL: r = shift_store(1, v);
				OP_LSR: r = shift_store(2, v);
				OP_ROR: r = shift_store(3, v);
				OP_BCC: taken = !reg_p[FL_C];
				OP_BCS: taken = reg_p[FL_C];
				OP_BNE: taken = !reg_p[FL_Z];
				OP_BEQ: taken = reg_p[FL_Z];
				OP_BPL: taken = !reg_p[FL_N];
				OP_BMI: taken = reg_p[FL_N];
				OP_BVC: taken = !reg_p[FL_V];
				OP_BVS: taken = reg_p[FL_V];
				OP_BIT: begin
					reg_p[FL_N] = v[7];
					reg_p[FL_V] = v[6];
					reg_p[FL_Z] = ((reg_a & v) == 8'h00);
				end
				OP_BRK: begin
					stack_push(ret[15:8]);
					stack_push(ret[7:0]);
					stack_push(reg_p | 8'h10);
					reg_p[FL_I] = 1'b1;
					npc = irq_vec;
				end
				OP_CLC: reg_p[FL_C] = 1'b0;
				OP_CLD: reg_p[FL_D] = 1'b0;
				OP_CLI: reg_p[FL_I] = 1'b0;
				OP_CLV: reg_p[FL_V] = 1'b0;
				OP_SEC: reg_p[FL_C] = 1'b1;
				OP_SED: reg_p[FL_D] = 1'b1;
				OP_SEI: reg_p[FL_I] = 1'b1;
				OP_CMP: r = compare(reg_a, v);
				OP_CPX: r = compare(reg_x, v);
				OP_CPY: r = compare(reg_y, v);
				OP_DEC: r = step_store(v, 1'b0);
				OP_INC: r = step_store(v, 1'b1);
				OP_DEX: begin reg_x--; set_nz(reg_x); end
				OP_DEY: begin reg_y--; set_nz(reg_y); end
				OP_INX: begin reg_x++; set_nz(reg_x); end
				OP_INY: begin reg_y++; set_nz(reg_y); end
				OP_JMP: npc = it.addr;
				OP_JSR: begin
					stack_push(ret[15:8]);
					stack_push(ret[7:0]);
					npc = it.addr;
				end
				OP_LDA: begin reg_a = v; set_nz(reg_a); end
				OP_LDX: begin reg_x = v; set_nz(reg_x); end
				OP_LDY: begin reg_y = v; set_nz(reg_y); end
				OP_PHA: stack_push(reg_a);
				OP_PHP: stack_push(reg_p | 8'h10);
				OP_PLA: begin reg_a = it.sb0; reg_s++; set_nz(reg_a); end
				OP_PLP, OP_RTI: begin
					// B and U are not real flip-flops; pulls leave them alone.
					reg_p = (it.sb0 & 8'hCF) | (reg_p & 8'h30);
					if (it.func == OP_RTI) begin
						npc = {it.sb2, it.sb1};
						reg_s = reg_s + 8'd3;
					end else
						reg_s++;
				end
				OP_RTS: begin
					npc = {it.sb1, it.sb0} + 16'd1;
					reg_s = reg_s + 8'd2;
				end
				OP_STA: store_val(reg_a);
				OP_STX: store_val(reg_x);
				OP_STY: store_val(reg_y);
				OP_SAX: store_val(reg_a & reg_x);
				OP_TAX: begin reg_x = reg_a; set_nz(reg_x); end
				OP_TAY: begin reg_y = reg_a; set_nz(reg_y); end
				OP_TSX: begin reg_x = reg_s; set_nz(reg_x); end
				OP_TXA: begin reg_a = reg_x; set_nz(reg_a); end
				OP_TYA: begin reg_a = reg_y; set_nz(reg_a); end
				OP_TXS: reg_s = reg_x;
				OP_AHX: emit_write(it.addr, reg_a & reg_x & hi1);
				OP_SHX: emit_write(it.addr, reg_x & hi1);
				OP_SHY: emit_write(it.addr, reg_y & hi1);
				OP_TAS: begin
					reg_s = reg_a & reg_x;
					emit_write(it.addr, reg_s & hi1);
				end
				OP_ALR: begin reg_a &= v; reg_a = shift_val(2, reg_a); end
				OP_ANC: begin
					reg_a &= v;
					set_nz(reg_a);
					reg_p[FL_C] = reg_a[7];
				end
				OP_ARR: begin
					reg_a &= v;
					reg_a = {reg_p[FL_C], reg_a[7:1]};
					set_nz(reg_a);
					reg_p[FL_C] = reg_a[6];
					reg_p[FL_V] = reg_a[6] ^ reg_a[5];
				end
				OP_AXS: reg_x = compare(reg_a & reg_x, v);
				// The accumulator form compares against the freshly stored A.
				OP_DCP: begin r = step_store(v, 1'b0); r = compare(reg_a, r); end
				OP_ISC: add_carry(~step_store(v, 1'b1));
				OP_SLO: begin r = shift_store(0, v); reg_a |= r; set_nz(reg_a); end
				OP_RLA: begin r = shift_store(1, v); reg_a &= r; set_nz(reg_a); end
				OP_SRE: begin r = shift_store(2, v); reg_a ^= r; set_nz(reg_a); end
				OP_RRA: add_carry(shift_store(3, v));
				OP_KIL: cpu_halted = 1'b1;
				OP_LAS: begin
					reg_a = v & reg_s;
					reg_x = reg_a;
					reg_s = reg_a;
					set_nz(reg_a);
				end
				OP_LAX: begin reg_a = v; reg_x = v; set_nz(reg_a); end
				OP_XAA: begin reg_a = reg_x & v; set_nz(reg_a); end
				default: ;
			endcase
			if (taken) begin
				off = {{8{it.opv[7]}}, it.opv};
				npc = it.pc + off;
				extra = (it.pc[15:8] != npc[15:8]) ? 2'd2 : 2'd1;
			end
		end
		n = (mem_wr_cnt != 0) ? mem_wr_cnt : 1;
		for (int k = 0; k < n; k++) begin
			res.new_pc = npc;
			res.wv = (k < mem_wr_cnt);
			res.waddr = res.wv ? mem_wr_addr[k] : 16'h0000;
			res.wdata = res.wv ? mem_wr_data[k] : 8'h00;
			res.last = (k == n - 1);
			res.extra = extra;
			res.halt = cpu_halted;
			res.a = reg_a;
			res.x = reg_x;
			res.y = reg_y;
			res.s = reg_s;
			res.p = reg_p;
			pending_results.push_back(res);
		end
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Result checker.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no instruction outstanding");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("new_pc", exp_r.new_pc, m_axis_tdata[15:0]);
				check_field("write_valid", exp_r.wv, m_axis_tdata[16]);
				check_field("write_address", exp_r.waddr, m_axis_tdata[32:17]);
				check_field("write_data", exp_r.wdata, m_axis_tdata[40:33]);
				check_field("last", exp_r.last, m_axis_tlast);
				check_field("extra_cycles", exp_r.extra, m_axis_tdata[42:41]);
				check_field("halt", exp_r.halt, m_axis_tdata[43]);
				check_field("a_value", exp_r.a, m_axis_tdata[51:44]);
				check_field("x_value", exp_r.x, m_axis_tdata[59:52]);
				check_field("y_value", exp_r.y, m_axis_tdata[67:60]);
				check_field("s_value", exp_r.s, m_axis_tdata[75:68]);
				check_field("p_value", exp_r.p, m_axis_tdata[83:76]);
			end
		end
	end

	// Result sink: rotates through always-ready, random and sparse stretches,
	// with one long hold-off on request.
	initial begin
		int cyc, hold_left;
		cyc = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = 300;
				m_axis_tready <= 1'b0;
			end else begin
				case ((cyc / 50) % 3)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_instr(input instr_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = no_gaps ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5));
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tdata <= {7'd0, it.sb2, it.sb1, it.sb0, it.pc, it.addr, it.opv, it.kind,
			it.func};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		execute_instr(it);
	endtask

	task automatic send_op(input logic [6:0] f, input logic [1:0] k, input logic [7:0] v,
			input logic [15:0] a = 16'h0300, input logic [15:0] pc = 16'h8002,
			input logic [7:0] b0 = 8'h00, input logic [7:0] b1 = 8'h00,
			input logic [7:0] b2 = 8'h00);
		instr_t it;
		it = '{func: f, kind: k, opv: v, addr: a, pc: pc, sb0: b0, sb1: b1, sb2: b2};
		send_instr(it);
	endtask

	function automatic instr_t random_instr();
		instr_t it;
		do
			it.func = 7'($urandom_range(0, 79));
		while (it.func == OP_KIL);
		it.kind = 2'($urandom_range(0, 3));
		it.opv = 8'($urandom);
		it.addr = 16'($urandom);
		it.pc = 16'($urandom);
		it.sb0 = 8'($urandom);
		it.sb1 = 8'($urandom);
		it.sb2 = 8'($urandom);
		return it;
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_irq_vector(input logic [15:0] vec);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= vec;
		do
			@(posedge clk);
		while (!cfg_ready);
		irq_vec = vec;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_op(OP_LDA, KIND_IMM, 8'h00);
		send_op(OP_LDA, KIND_IMM, 8'h80);
		send_op(OP_LDA, KIND_IMM, 8'h7F);
		send_op(OP_ADC, KIND_IMM, 8'h01);
		send_op(OP_SEC, KIND_IMP, 8'h00);
		send_op(OP_SBC, KIND_MEM, 8'hFF, 16'hFFFF);
		send_op(OP_CMP, KIND_IMM, 8'h7F);
		send_op(OP_ASL, KIND_ACC, 8'h00);
		send_op(OP_ROR, KIND_MEM, 8'h01, 16'h0000);
		// Branches: BCS taken across a page forward, BEQ at address zero not taken, BNE taken.
		send_op(OP_BCS, KIND_IMM, 8'h20, 16'h0000, 16'h10F0);
		send_op(OP_BEQ, KIND_IMM, 8'h80, 16'h0000, 16'h0000);
		send_op(OP_BNE, KIND_IMM, 8'h05, 16'h0000, 16'h2010);
		send_op(OP_BRK, KIND_IMP, 8'h00, 16'h0000, 16'h0000);
		send_op(OP_JSR, KIND_MEM, 8'h00, 16'hFFFF, 16'hFFFF);
		send_op(OP_RTS, KIND_IMP, 8'h00, 16'h0000, 16'h0000, 8'hFF, 8'hFF);
		send_op(OP_RTI, KIND_IMP, 8'h00, 16'h0000, 16'h0000, 8'hFF, 8'h34, 8'h12);
		send_op(OP_PHP, KIND_IMP, 8'h00);
		send_op(OP_PLP, KIND_IMP, 8'h00, 16'h0000, 16'h0000, 8'h00);
		send_op(OP_LDX, KIND_IMM, 8'hFF);
		send_op(OP_TXS, KIND_IMP, 8'h00);
		send_op(OP_PHA, KIND_IMP, 8'h00);
		// Store of a high-byte-masked register ignores the operand kind.
		send_op(OP_SHX, KIND_IMP, 8'h00, 16'hFE00);
		send_op(OP_SEC, KIND_IMP, 8'h00);
		send_op(OP_ARR, KIND_IMM, 8'hFF);
		send_op(OP_ISC, KIND_ACC, 8'h00);
	endtask

	task automatic test_every_code();
		instr_t it;
		for (int f = 0; f < 80; f++) begin
			if (f == OP_KIL)
				continue;
			it = random_instr();
			it.func = 7'(f);
			send_instr(it);
		end
		send_op(OP_NOP_CODE, KIND_IMP, 8'h00);
	endtask

	task automatic test_backpressure();
		instr_t it;
		@(posedge clk);
		hold_req = 1;
		no_gaps = 1;
		for (int i = 0; i < 30; i++) begin
			it = random_instr();
			if (i % 3 == 0)
				it.func = OP_BRK;
			else if (i % 3 == 1)
				it.func = OP_JSR;
			send_instr(it);
		end
		no_gaps = 0;
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_instr(random_instr());
	endtask

	task automatic test_halt();
		send_op(OP_KIL, KIND_IMP, 8'h00);
		test_random(6);
	endtask

	initial begin
		reg_a = 8'h00;
		reg_x = 8'h00;
		reg_y = 8'h00;
		reg_s = SP_RESET;
		reg_p = STATUS_RESET;
		cpu_halted = 1'b0;
		irq_vec = 16'h0000;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		send_op(OP_BRK, KIND_IMP, 8'h00, 16'h0000, 16'h1234);
		write_irq_vector(16'hFFFF);
		test_directed();
		test_every_code();
		write_irq_vector(16'h0000);
		test_backpressure();
		test_random(45);
		write_irq_vector(16'($urandom));
		test_random(45);
		test_halt();
		wait_drained();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
